[design/march_memory_test_controller_top_assert.svh]
// -----------------------------------------------------------------------------
// March memory test controller: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// -----------------------------------------------------------------------------
`ifndef MARCH_MEMORY_TEST_CONTROLLER_TOP_ASSERT_SVH
`define MARCH_MEMORY_TEST_CONTROLLER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MMT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

[design/mmt_pkg.sv]
// -----------------------------------------------------------------------------
// March memory test controller package
// Phase and expected-data codes, register indexes and shared types.
// -----------------------------------------------------------------------------
package mmt_pkg;

  // Default widths of the memory address and data buses.
  localparam int unsigned AddrWidthDefault = 12;
  localparam int unsigned DataWidthDefault = 8;

  // Reset values of the address range registers.
  localparam int unsigned StartAddrReset = 256;
  localparam int unsigned EndAddrReset   = 2304;

  // Configuration register indexes.
  localparam int unsigned CfgIndexWidth = 1;
  localparam logic [CfgIndexWidth-1:0] CfgStartAddr = 1'b0;
  localparam logic [CfgIndexWidth-1:0] CfgEndAddr   = 1'b1;

  // March sequencer phases.
  typedef enum logic [3:0] {
    PhIdle,
    PhW0,
    PhR0,
    PhW1,
    PhR1,
    PhW0d,
    PhR0d,
    PhCheck,
    PhDone
  } phase_e;

  // Value expected from the read issued in the previous word.
  typedef enum logic [1:0] {
    ExpNone,
    ExpZero,
    ExpOnes
  } expect_e;

  // Command and status flags of one result word.
  typedef struct packed {
    logic mem_read;
    logic mem_write;
    logic busy;
    logic done;
    logic fail;
  } cmd_flags_t;

endpackage

[design/mmt_cfg_regs.sv]
// -----------------------------------------------------------------------------
// March memory test controller: configuration registers
// Holds the start and exclusive end address of the tested range.
// -----------------------------------------------------------------------------
module mmt_cfg_regs #(
  parameter int unsigned ADDR_WIDTH = mmt_pkg::AddrWidthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mmt_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [ADDR_WIDTH-1:0]              cfg_data_i,
  output logic [ADDR_WIDTH-1:0]              start_addr_o,
  output logic [ADDR_WIDTH-1:0]              end_addr_o
);
  import mmt_pkg::*;

  logic [ADDR_WIDTH-1:0] start_addr_q, start_addr_d;
  logic [ADDR_WIDTH-1:0] end_addr_q, end_addr_d;
  logic                  cfg_write;

  // The register file takes a word in every cycle.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // Register index decode.
  always_comb begin
    start_addr_d = start_addr_q;
    end_addr_d   = end_addr_q;
    if (cfg_write) begin
      unique case (cfg_index_i)
        CfgStartAddr: start_addr_d = cfg_data_i;
        CfgEndAddr:   end_addr_d   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_addr_q <= ADDR_WIDTH'(StartAddrReset);
      end_addr_q   <= ADDR_WIDTH'(EndAddrReset);
    end else begin
      start_addr_q <= start_addr_d;
      end_addr_q   <= end_addr_d;
    end
  end

  assign start_addr_o = start_addr_q;
  assign end_addr_o   = end_addr_q;

endmodule

[design/mmt_march_core.sv]
// -----------------------------------------------------------------------------
// March memory test controller: MATS++ sequencer core
// Holds the march state, checks returned read data and forms the command of
// the current word; the state advances on each step.
// -----------------------------------------------------------------------------
module mmt_march_core #(
  parameter int unsigned ADDR_WIDTH = mmt_pkg::AddrWidthDefault,
  parameter int unsigned DATA_WIDTH = mmt_pkg::DataWidthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic                    action_i,
  input  logic [DATA_WIDTH-1:0]   read_data_i,
  input  logic [ADDR_WIDTH-1:0]   start_addr_i,
  input  logic [ADDR_WIDTH-1:0]   end_addr_i,
  output logic [ADDR_WIDTH-1:0]   mem_address_o,
  output logic [DATA_WIDTH-1:0]   mem_write_data_o,
  output logic [ADDR_WIDTH-1:0]   fail_address_o,
  output mmt_pkg::cmd_flags_t     flags_o
);
  import mmt_pkg::*;

  `include "march_memory_test_controller_top_assert.svh"

  phase_e                phase_q, phase_d;
  expect_e               exp_q, exp_d;
  logic [ADDR_WIDTH-1:0] cur_q, cur_d;
  logic                  failed_q, failed_d;
  logic [ADDR_WIDTH-1:0] ffa_q, ffa_d;
  logic                  fin_q, fin_d;

  logic                  active;
  logic [DATA_WIDTH-1:0] want;
  logic [ADDR_WIDTH-1:0] rd_addr;
  logic                  mismatch;
  logic                  inc_ok;
  logic                  issue;

  logic [ADDR_WIDTH-1:0] cmd_addr;
  logic [DATA_WIDTH-1:0] cmd_wdata;
  logic                  cmd_rd;
  logic                  cmd_wr;

  // Read-back check of the outstanding read. In the descending read-1 phase
  // the address has already stepped down, so the read was one above it.
  assign active   = (phase_q != PhIdle) && (phase_q != PhDone);
  assign want     = (exp_q == ExpOnes) ? {DATA_WIDTH{1'b1}} : '0;
  assign rd_addr  = (phase_q == PhR1) ? (cur_q + ADDR_WIDTH'(1)) : cur_q;
  assign mismatch = !action_i && active && (exp_q != ExpNone) && (read_data_i != want);
  assign issue    = !action_i && active && !mismatch;

  // An ascending element continues while the next address stays below the end.
  assign inc_ok = (({1'b0, cur_q} + (ADDR_WIDTH + 1)'(1)) < {1'b0, end_addr_i});

  // Next state.
  always_comb begin
    phase_d  = phase_q;
    exp_d    = exp_q;
    cur_d    = cur_q;
    failed_d = failed_q;
    ffa_d    = ffa_q;
    fin_d    = fin_q;
    if (action_i) begin
      exp_d    = ExpNone;
      failed_d = 1'b0;
      ffa_d    = '0;
      cur_d    = start_addr_i;
      if (start_addr_i >= end_addr_i) begin
        fin_d   = 1'b1;
        phase_d = PhDone;
      end else begin
        fin_d   = 1'b0;
        phase_d = PhW0;
      end
    end else if (!active) begin
      exp_d = ExpNone;
    end else if (mismatch) begin
      exp_d    = ExpNone;
      failed_d = 1'b1;
      ffa_d    = rd_addr;
      fin_d    = 1'b1;
      phase_d  = PhDone;
    end else begin
      exp_d = ExpNone;
      unique case (phase_q)
        PhW0: begin
          if (inc_ok) begin
            cur_d = cur_q + ADDR_WIDTH'(1);
          end else begin
            phase_d = PhR0;
            cur_d   = start_addr_i;
          end
        end
        PhR0: begin
          exp_d   = ExpZero;
          phase_d = PhW1;
        end
        PhW1: begin
          if (inc_ok) begin
            cur_d   = cur_q + ADDR_WIDTH'(1);
            phase_d = PhR0;
          end else begin
            phase_d = PhR1;
            cur_d   = (end_addr_i > start_addr_i) ? (end_addr_i - ADDR_WIDTH'(1))
                                                  : start_addr_i;
          end
        end
        PhR1: begin
          exp_d   = ExpOnes;
          phase_d = PhW0d;
        end
        PhW0d: begin
          phase_d = PhR0d;
        end
        PhR0d: begin
          exp_d = ExpZero;
          if (cur_q <= start_addr_i) begin
            phase_d = PhCheck;
          end else begin
            cur_d   = cur_q - ADDR_WIDTH'(1);
            phase_d = PhR1;
          end
        end
        default: begin
          // Final check cycle: the last read matched.
          fin_d   = 1'b1;
          phase_d = PhDone;
        end
      endcase
    end
  end

  // Command of the current word.
  always_comb begin
    cmd_addr  = '0;
    cmd_wdata = '0;
    cmd_rd    = 1'b0;
    cmd_wr    = 1'b0;
    if (issue) begin
      unique case (phase_q)
        PhW0: begin
          cmd_addr = cur_q;
          cmd_wr   = 1'b1;
        end
        PhR0: begin
          cmd_addr = cur_q;
          cmd_rd   = 1'b1;
        end
        PhW1: begin
          cmd_addr  = cur_q;
          cmd_wr    = 1'b1;
          cmd_wdata = {DATA_WIDTH{1'b1}};
        end
        PhR1: begin
          cmd_addr = cur_q;
          cmd_rd   = 1'b1;
        end
        PhW0d: begin
          cmd_addr = cur_q;
          cmd_wr   = 1'b1;
        end
        PhR0d: begin
          cmd_addr = cur_q;
          cmd_rd   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // State registers advance once per step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      exp_q    <= ExpNone;
      cur_q    <= '0;
      failed_q <= 1'b0;
      ffa_q    <= '0;
      fin_q    <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      exp_q    <= exp_d;
      cur_q    <= cur_d;
      failed_q <= failed_d;
      ffa_q    <= ffa_d;
      fin_q    <= fin_d;
    end
  end

  // Status reflects the state after this word.
  assign mem_address_o     = cmd_addr;
  assign mem_write_data_o  = cmd_wdata;
  assign fail_address_o    = ffa_d;
  assign flags_o.mem_read  = cmd_rd;
  assign flags_o.mem_write = cmd_wr;
  assign flags_o.busy      = (phase_d != PhIdle) && (phase_d != PhDone);
  assign flags_o.done      = fin_d;
  assign flags_o.fail      = failed_d;

  // A failure always halts the test in the done phase.
  `MMT_ASSERT_SAME(a_fail_halts, failed_q, fin_q && (phase_q == PhDone))
  // A start clears the outstanding read and the fail status.
  `MMT_ASSERT_NEXT(a_start_clears, step_i && action_i, (exp_q == ExpNone) && !failed_q)
  // The all-ones pattern goes out only with a write command.
  `MMT_ASSERT_SAME(a_wdata_on_write, cmd_wdata != '0, cmd_wr && !cmd_rd)
  // A mismatch records the address of the read that failed.
  `MMT_ASSERT_NEXT(a_mismatch_addr, step_i && mismatch, failed_q && (ffa_q == $past(rd_addr)))

endmodule

[design/march_memory_test_controller_top.sv]
// -----------------------------------------------------------------------------
// March memory test controller top level
// MATS++ sequencer with input register, result register and config port.
// -----------------------------------------------------------------------------
// Usage: each input word on the in channel (in_valid_i / in_stall_o) is either
// a start (action_i = 1) or a tick (action_i = 0) carrying the read data for
// the read issued in the previous result. Every accepted word yields exactly
// one result word on the out channel (out_valid_o / out_stall_i) with the
// memory command of that cycle and the test status.
// An accepted word lands in the input register; its result enters the result
// register when that is free or its word is taken. Throughput: one word per
// cycle while the receiver does not stall; the sequencer state updates once
// per accepted word. The config port (cfg_valid_i / cfg_ready_o) sets the
// start and exclusive end address and is always ready; the user must write it
// only while the block is idle, as the block does not enforce this. Reset
// empties both registers, puts the sequencer in idle and restores the default
// address range. When the receiver stalls, the result holds and the input
// register refills once; in_stall_o then rises until the result moves.
// -----------------------------------------------------------------------------
module march_memory_test_controller_top #(
  parameter int unsigned ADDR_WIDTH = mmt_pkg::AddrWidthDefault,
  parameter int unsigned DATA_WIDTH = mmt_pkg::DataWidthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               action_i,
  input  logic [DATA_WIDTH-1:0]              read_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ADDR_WIDTH-1:0]              mem_address_o,
  output logic                               mem_read_o,
  output logic                               mem_write_o,
  output logic [DATA_WIDTH-1:0]              mem_write_data_o,
  output logic                               busy_res_o,
  output logic                               done_res_o,
  output logic                               fail_o,
  output logic [ADDR_WIDTH-1:0]              fail_address_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mmt_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [ADDR_WIDTH-1:0]              cfg_data_i
);
  import mmt_pkg::*;

  logic                  in_valid_q, in_valid_d;
  logic                  in_action_q;
  logic [DATA_WIDTH-1:0] in_rdata_q;
  logic                  out_valid_q, out_valid_d;
  logic [ADDR_WIDTH-1:0] res_addr_q;
  logic [DATA_WIDTH-1:0] res_wdata_q;
  logic [ADDR_WIDTH-1:0] res_ffa_q;
  cmd_flags_t            res_flags_q;

  logic                  load;
  logic                  advance;
  logic [ADDR_WIDTH-1:0] start_addr;
  logic [ADDR_WIDTH-1:0] end_addr;
  logic [ADDR_WIDTH-1:0] core_addr;
  logic [DATA_WIDTH-1:0] core_wdata;
  logic [ADDR_WIDTH-1:0] core_ffa;
  cmd_flags_t            core_flags;

  // Address range registers.
  mmt_cfg_regs #(
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .start_addr_o(start_addr),
    .end_addr_o  (end_addr)
  );

  // Handshake: the input word moves on when the result register is free or
  // its word is taken in the same cycle.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (load) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      in_action_q <= action_i;
      in_rdata_q  <= read_data_i;
    end
  end

  // Sequencer core.
  mmt_march_core #(
    .ADDR_WIDTH(ADDR_WIDTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .action_i        (in_action_q),
    .read_data_i     (in_rdata_q),
    .start_addr_i    (start_addr),
    .end_addr_i      (end_addr),
    .mem_address_o   (core_addr),
    .mem_write_data_o(core_wdata),
    .fail_address_o  (core_ffa),
    .flags_o         (core_flags)
  );

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_addr_q  <= core_addr;
      res_wdata_q <= core_wdata;
      res_ffa_q   <= core_ffa;
      res_flags_q <= core_flags;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign mem_address_o    = res_addr_q;
  assign mem_read_o       = res_flags_q.mem_read;
  assign mem_write_o      = res_flags_q.mem_write;
  assign mem_write_data_o = res_wdata_q;
  assign busy_res_o       = res_flags_q.busy;
  assign done_res_o       = res_flags_q.done;
  assign fail_o           = res_flags_q.fail;
  assign fail_address_o   = res_ffa_q;

endmodule
